[sv/spo2_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the SpO2 ratio estimator.
package spo2_pkg;
  localparam int unsigned ThreshBits  = 18;
  localparam int unsigned PctBits     = 7;
  localparam logic [ThreshBits-1:0] ThreshReset = 18'd50000;
  localparam logic [PctBits-1:0] PctCap   = 7'd100;
  localparam logic [PctBits-1:0] PctFloor = 7'd70;
  localparam logic [PctBits-1:0] PctBase  = 7'd110;
  localparam logic [4:0] RatioGain = 5'd25;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture samples, check threshold
    logic lowpass;    // update levels from captured samples
    logic write_res;  // write residues into the windows
    logic scan_clr;   // reset min/max trackers
    logic scan_step;  // read next window entry
    logic scan_acc;   // fold registered read data into min/max
    logic prod_start; // form numerator and denominator
    logic prod_step;  // one partial-product step
    logic div_start;  // start the serial divider
    logic div_step;   // one quotient bit
    logic finish;     // form result
  } spo2_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic no_finger;
    logic scan_last;
    logic prod_last;
    logic div_last;
  } spo2_sts_t;
endpackage

[sv/spo2_datapath.sv]
`timescale 1ns / 1ps
// Datapath: DC levels, residue windows, peak-to-peak scan and serial divider.
module spo2_datapath #(
  parameter int unsigned WindowDepth = 32,
  parameter int unsigned SampleBits  = 18
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  spo2_pkg::spo2_cmd_t               cmd_i,
  output spo2_pkg::spo2_sts_t               sts_o,
  input  logic [SampleBits-1:0]             red_sample_i,
  input  logic [SampleBits-1:0]             ir_sample_i,
  input  logic [spo2_pkg::ThreshBits-1:0]   threshold_i,
  output logic [spo2_pkg::PctBits-1:0]      spo2_percent_o
);
  import spo2_pkg::*;

  localparam int unsigned AddrBits = (WindowDepth > 1) ? $clog2(WindowDepth) : 1;
  localparam int unsigned ResBits  = SampleBits + 1;
  localparam int unsigned PpBits   = SampleBits + 2;
  localparam int unsigned DenBits  = PpBits + SampleBits;
  localparam int unsigned NumBits  = DenBits + 5;
  localparam int unsigned DivCntBits = $clog2(NumBits + 1);
  localparam int unsigned PrdCntBits = $clog2(SampleBits + 1);
  localparam int unsigned LvlBits  = SampleBits + 5;
  localparam logic [AddrBits-1:0] LastAddr = AddrBits'(WindowDepth - 1);

  logic [SampleBits-1:0] red_q, ir_q, red_lvl_q, ir_lvl_q;
  logic [AddrBits-1:0]   slot_q, rd_addr_q;
  logic [WindowDepth-1:0] valid_q;
  logic [ResBits-1:0]    red_mem [WindowDepth];
  logic [ResBits-1:0]    ir_mem  [WindowDepth];
  logic [ResBits-1:0]    red_rd_q, ir_rd_q;
  logic                  rd_valid_q;
  logic signed [ResBits-1:0] red_min_q, red_max_q, ir_min_q, ir_max_q;
  logic [PpBits-1:0]     red_pp, ir_pp;
  logic [NumBits-1:0]    num_q, mcand_q;
  logic [DenBits-1:0]    den_q;
  logic [SampleBits-1:0] mplier_q, mplier2_q;
  logic [PpBits-1:0]     dcand_q;
  logic [PrdCntBits-1:0] prd_cnt_q;
  logic [NumBits-1:0]    quo_q;
  logic [DenBits:0]      rem_q;
  logic [DivCntBits-1:0] div_cnt_q;
  logic                  zero_q;
  logic [PctBits-1:0]    pct_q;

  // Level filter: floor((19*level + x) / 20) via reciprocal with correction.
  // The reciprocal ceil(2^33 / 20) is exact for every sum below 2^30.
  function automatic logic [SampleBits-1:0] lowpass(input logic [SampleBits-1:0] lv,
                                                   input logic [SampleBits-1:0] x);
    logic [LvlBits-1:0] s;
    logic [LvlBits+28:0] p;
    logic [LvlBits-1:0] q, r;
    s = LvlBits'(lv) * LvlBits'(19) + LvlBits'(x);
    p = (LvlBits+29)'(s) * (LvlBits+29)'(29'd429496730);
    q = LvlBits'(p >> 33);
    r = s - q * LvlBits'(20);
    if (r >= LvlBits'(20)) q = q + LvlBits'(1);
    return SampleBits'(q);
  endfunction

  logic [SampleBits-1:0] red_lv_n, ir_lv_n;
  assign red_lv_n = lowpass(red_lvl_q, red_q);
  assign ir_lv_n  = lowpass(ir_lvl_q, ir_q);

  assign sts_o.no_finger = (ir_q < SampleBits'(threshold_i)) ||
                           (red_q < SampleBits'(threshold_i)) ||
                           ((SampleBits < ThreshBits) &&
                            (threshold_i >> SampleBits) != '0);
  assign sts_o.scan_last = (rd_addr_q == LastAddr);
  assign sts_o.prod_last = (prd_cnt_q == PrdCntBits'(SampleBits - 1));
  assign sts_o.div_last  = (div_cnt_q == DivCntBits'(NumBits - 1));

  // Residue memories; written once per item, read one entry per cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_res) begin
      red_mem[slot_q] <= ResBits'({1'b0, red_q}) - ResBits'({1'b0, red_lvl_q});
      ir_mem[slot_q]  <= ResBits'({1'b0, ir_q}) - ResBits'({1'b0, ir_lvl_q});
    end
    red_rd_q <= red_mem[rd_addr_q];
    ir_rd_q  <= ir_mem[rd_addr_q];
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_lvl_q  <= '0;
      ir_lvl_q   <= '0;
      slot_q     <= '0;
      valid_q    <= '0;
      rd_addr_q  <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.lowpass) begin
        red_lvl_q <= red_lv_n;
        ir_lvl_q  <= ir_lv_n;
      end
      if (cmd_i.write_res) begin
        valid_q[slot_q] <= 1'b1;
        slot_q <= (slot_q == LastAddr) ? '0 : slot_q + AddrBits'(1);
      end
      if (cmd_i.scan_clr) rd_addr_q <= '0;
      else if (cmd_i.scan_step && rd_addr_q != LastAddr) rd_addr_q <= rd_addr_q + AddrBits'(1);
      rd_valid_q <= cmd_i.scan_step ? valid_q[rd_addr_q] : rd_valid_q;
    end
  end

  // Window scan, pp math and divide.
  logic signed [ResBits-1:0] red_v, ir_v;
  logic [DenBits:0] rem_sh;
  assign red_v = rd_valid_q ? $signed(red_rd_q) : '0;
  assign ir_v  = rd_valid_q ? $signed(ir_rd_q) : '0;
  assign red_pp = PpBits'($signed({red_max_q[ResBits-1], red_max_q}) -
                          $signed({red_min_q[ResBits-1], red_min_q}));
  assign ir_pp  = PpBits'($signed({ir_max_q[ResBits-1], ir_max_q}) -
                          $signed({ir_min_q[ResBits-1], ir_min_q}));
  assign rem_sh = {rem_q[DenBits-1:0], num_q[NumBits-1]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      red_q <= red_sample_i;
      ir_q  <= ir_sample_i;
      pct_q <= '0;
    end
    // Trackers start at the opposite extremes so every entry takes part.
    if (cmd_i.scan_clr) begin
      red_min_q <= {1'b0, {(ResBits-1){1'b1}}};
      red_max_q <= {1'b1, {(ResBits-1){1'b0}}};
      ir_min_q  <= {1'b0, {(ResBits-1){1'b1}}};
      ir_max_q  <= {1'b1, {(ResBits-1){1'b0}}};
    end else if (cmd_i.scan_acc) begin
      if (red_v < red_min_q) red_min_q <= red_v;
      if (red_v > red_max_q) red_max_q <= red_v;
      if (ir_v < ir_min_q) ir_min_q <= ir_v;
      if (ir_v > ir_max_q) ir_max_q <= ir_v;
    end
    // Shift-add products: num = 25*red_pp*ir_lvl, den = red_lvl*ir_pp.
    if (cmd_i.prod_start) begin
      zero_q    <= (red_pp == '0) || (ir_pp == '0) || (red_lvl_q == '0) || (ir_lvl_q == '0);
      num_q     <= '0;
      den_q     <= '0;
      mcand_q   <= NumBits'(red_pp) * NumBits'(RatioGain);
      mplier_q  <= ir_lvl_q;
      mplier2_q <= red_lvl_q;
      dcand_q   <= ir_pp;
      prd_cnt_q <= '0;
    end else if (cmd_i.prod_step) begin
      if (mplier_q[0])
        num_q <= num_q + (mcand_q << prd_cnt_q);
      if (mplier2_q[0])
        den_q <= den_q + (DenBits'(dcand_q) << prd_cnt_q);
      mplier_q  <= mplier_q >> 1;
      mplier2_q <= mplier2_q >> 1;
      prd_cnt_q <= prd_cnt_q + PrdCntBits'(1);
    end
    // Restoring divider, one quotient bit per cycle; num_q shifts out.
    if (cmd_i.div_start) begin
      rem_q     <= '0;
      quo_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[NumBits-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NumBits-2:0], 1'b0};
      end
      num_q     <= num_q << 1;
      div_cnt_q <= div_cnt_q + DivCntBits'(1);
    end
    // Ceiling, offset and clamps.
    if (cmd_i.finish) begin
      logic [NumBits-1:0] c;
      c = quo_q + NumBits'(rem_q != '0);
      if (zero_q || c > NumBits'(PctBase - PctFloor)) pct_q <= '0;
      else if (c < NumBits'(PctBase - PctCap)) pct_q <= PctCap;
      else pct_q <= PctBase - PctBits'(c);
    end
  end

  assign spo2_percent_o = pct_q;
endmodule

[sv/spo2_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences one request through filter, scan, products and divide.
module spo2_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output spo2_pkg::spo2_cmd_t cmd_o,
  input  spo2_pkg::spo2_sts_t sts_i
);
  import spo2_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StCheck, StFilter, StWrite, StScan, StScanTail, StProdInit, StProd, StDiv,
    StFinish, StOut
  } state_e;

  state_e state_q;
  logic   tail_q;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    cmd_o = '0;
    cmd_o.load       = (state_q == StIdle) && in_valid_i;
    cmd_o.lowpass    = (state_q == StCheck) && !sts_i.no_finger;
    cmd_o.write_res  = (state_q == StFilter);
    cmd_o.scan_clr   = (state_q == StWrite);
    cmd_o.scan_step  = (state_q == StScan);
    cmd_o.scan_acc   = ((state_q == StScan) && tail_q) || (state_q == StScanTail);
    cmd_o.prod_start = (state_q == StProdInit);
    cmd_o.prod_step  = (state_q == StProd);
    cmd_o.div_start  = (state_q == StProd) && sts_i.prod_last;
    cmd_o.div_step   = (state_q == StDiv);
    cmd_o.finish     = (state_q == StFinish);
  end

  // State register; tail_q marks that registered read data is present.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      tail_q  <= 1'b0;
    end else begin
      case (state_q)
        StIdle:     if (in_valid_i) state_q <= StCheck;
        StCheck:    state_q <= sts_i.no_finger ? StOut : StFilter;
        StFilter:   state_q <= StWrite;
        StWrite:    begin state_q <= StScan; tail_q <= 1'b0; end
        StScan: begin
          tail_q <= 1'b1;
          if (sts_i.scan_last) state_q <= StScanTail;
        end
        StScanTail: state_q <= StProdInit;
        StProdInit: state_q <= StProd;
        StProd:     if (sts_i.prod_last) state_q <= StDiv;
        StDiv:      if (sts_i.div_last) state_q <= StFinish;
        StFinish:   state_q <= StOut;
        StOut:      if (!out_stall_i) state_q <= StIdle;
        default:    state_q <= StIdle;
      endcase
    end
  end

  property p_out_holds;
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && out_stall_i) |=> out_valid_o;
  endproperty
  a_out_holds: assert property (p_out_holds) else $error("result dropped while stalled");

  property p_one_busy;
    @(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o;
  endproperty
  a_one_busy: assert property (p_one_busy) else $error("input open during result");

  property p_load_idle;
    @(posedge clk_i) disable iff (!rst_ni) cmd_o.load |=> (state_q == StCheck);
  endproperty
  a_load_idle: assert property (p_load_idle) else $error("load did not start work");
endmodule

[sv/spo2_ratio_estimator.sv]
`timescale 1ns / 1ps
// SpO2 ratio-of-ratios estimator top level.
// One request at a time: sample check, DC filter and residue write, then the window
// scan, product setup, shift-add products, the serial divider and forming the result.
// A stalled result holds off the next request. A no-finger request returns 0 straight
// after the sample check. The scan over the residue memories and the serial divider set
// the time that a request takes.
module spo2_ratio_estimator #(
  parameter int unsigned WINDOW_DEPTH = 32,
  parameter int unsigned SAMPLE_BITS  = 18
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [SAMPLE_BITS-1:0]          red_sample_i,
  input  logic [SAMPLE_BITS-1:0]          ir_sample_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [spo2_pkg::PctBits-1:0]    spo2_percent_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [spo2_pkg::ThreshBits-1:0] cfg_data_i
);
  import spo2_pkg::*;

  logic [ThreshBits-1:0] thresh_q;
  spo2_cmd_t cmd;
  spo2_sts_t sts;

  assign cfg_ready_o = 1'b1;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) thresh_q <= ThreshReset;
    else if (cfg_valid_i) thresh_q <= cfg_data_i;
  end

  spo2_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  spo2_datapath #(.WindowDepth(WINDOW_DEPTH), .SampleBits(SAMPLE_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .red_sample_i, .ir_sample_i,
    .threshold_i(thresh_q), .spo2_percent_o
  );
endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the SpO2 ratio-of-ratios estimator.
module testbench;
  import spo2_pkg::*;

  localparam int unsigned Depth = 32;
  localparam int unsigned SBits = 18;
  localparam int unsigned MaxSample = (1 << SBits) - 1;

  typedef struct {
    logic [SBits-1:0]   red;
    logic [SBits-1:0]   ir;
    bit                 known;
    logic [PctBits-1:0] pct;
  } sample_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [SBits-1:0]      red_sample_i = '0;
  logic [SBits-1:0]      ir_sample_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [PctBits-1:0]    spo2_percent_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [ThreshBits-1:0] cfg_data_i = '0;

  // Predictor state.
  logic [ThreshBits-1:0] thresh_q;
  logic [SBits-1:0]      ir_dc, red_dc;
  int                    ir_res[Depth];
  int                    red_res[Depth];
  int unsigned           slot;

  logic [PctBits-1:0] pending_spo2[$];
  int unsigned errors = 0;
  int unsigned n_sent = 0, n_checked = 0, n_zero = 0, n_reading = 0;
  bit          quiet = 1'b0;
  int unsigned wave_t = 0;

  spo2_ratio_estimator u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .red_sample_i, .ir_sample_i,
    .out_valid_o, .out_stall_i, .spo2_percent_o, .cfg_valid_i, .cfg_ready_o,
    .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  // Hard limit on the run time.
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint unsigned window_span(input int w[Depth]);
    int lo, hi;
    lo = w[0];
    hi = w[0];
    for (int i = 1; i < Depth; i++) begin
      if (w[i] < lo) lo = w[i];
      if (w[i] > hi) hi = w[i];
    end
    return longint'(hi) - longint'(lo);
  endfunction

  // Advances the estimator state by one sample, unless it is a no-finger sample, and returns the reading.
  function automatic logic [PctBits-1:0] predict_spo2(input logic [SBits-1:0] r,
                                                      input logic [SBits-1:0] ir);
    longint unsigned ir_pp, red_pp, num, den, c;
    if (ir < thresh_q || r < thresh_q) return '0;
    ir_dc  = SBits'((32'd19 * ir_dc + ir) / 32'd20);
    red_dc = SBits'((32'd19 * red_dc + r) / 32'd20);
    ir_res[slot]  = int'(ir) - int'(ir_dc);
    red_res[slot] = int'(r) - int'(red_dc);
    slot = (slot + 1) % Depth;
    ir_pp  = window_span(ir_res);
    red_pp = window_span(red_res);
    if (ir_pp == 0 || red_pp == 0 || ir_dc == 0 || red_dc == 0) return '0;
    num = 25 * red_pp * ir_dc;
    den = red_dc * ir_pp;
    c = (num + den - 1) / den;
    if (c > 110) return '0;
    if (110 - c > 100) return PctCap;
    if (110 - c < 70) return '0;
    return PctBits'(110 - c);
  endfunction

  // Sends one request; called and returning at a falling edge.
  task automatic send_sample(input logic [SBits-1:0] r, input logic [SBits-1:0] ir,
                             input bit known, input logic [PctBits-1:0] pct);
    int unsigned gap;
    logic [PctBits-1:0] p;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    red_sample_i <= r;
    ir_sample_i  <= ir;
    do @(posedge clk_i); while (in_stall_o);
    p = predict_spo2(r, ir);
    if (known && p !== pct) begin
      $display("%0t: table row disagrees with predictor: expected %0d, predicted %0d",
               $time, pct, p);
      errors++;
    end
    pending_spo2.push_back(known ? pct : p);
    n_sent++;
    @(negedge clk_i);
  endtask

  // Random sample pair: mostly pulse-like waveforms, some noise and no-finger cases.
  task automatic send_random();
    int unsigned kind, lo, dc_r, dc_i, amp_r, amp_i, tri_v;
    logic [SBits-1:0] r, ir;
    kind = $urandom_range(0, 99);
    if (kind < 70 && thresh_q < 200000) begin
      lo = (thresh_q < 60000) ? 60000 : thresh_q;
      wave_t++;
      dc_r  = lo + ((wave_t / 40) * 7919) % (220000 - lo);
      dc_i  = lo + ((wave_t / 40) * 5417 + 3001) % (220000 - lo);
      amp_r = 200 + $urandom_range(0, 3000);
      amp_i = 200 + $urandom_range(0, 3000);
      tri_v = wave_t % 20;
      tri_v = (tri_v < 10) ? tri_v : 20 - tri_v;
      r  = SBits'(dc_r + amp_r * tri_v / 10 + $urandom_range(0, 50));
      ir = SBits'(dc_i + amp_i * tri_v / 10 + $urandom_range(0, 50));
    end else if (kind < 85 || thresh_q == 0) begin
      r  = SBits'($urandom);
      ir = SBits'($urandom);
    end else begin
      r  = SBits'($urandom_range(0, thresh_q - 1));
      ir = $urandom_range(0, 1) ? SBits'($urandom) : SBits'($urandom_range(0, thresh_q - 1));
      if ($urandom_range(0, 1)) {r, ir} = {ir, r};
    end
    send_sample(r, ir, 1'b0, '0);
  endtask

  task automatic send_burst(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      quiet = (i % 100) < 15;
      send_random();
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;
  endtask

  // Waits until every expected reading has arrived, plus a margin.
  task automatic drain();
    while (pending_spo2.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_threshold(input logic [ThreshBits-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    thresh_q = v;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Result side: random stall per result, then compare with the oldest expectation.
  initial begin
    int unsigned n;
    logic [PctBits-1:0] want;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      if (pending_spo2.size() == 0) begin
        $display("%0t: unexpected reading %0d", $time, spo2_percent_o);
        errors++;
      end else begin
        want = pending_spo2.pop_front();
        if (spo2_percent_o !== want) begin
          $display("%0t: spo2_percent expected %0d, actual %0d", $time, want, spo2_percent_o);
          errors++;
        end
        n_checked++;
        if (want == 0) n_zero++;
        else n_reading++;
      end
      @(negedge clk_i);
    end
  end

  // Stimulus sequence.
  initial begin
    sample_row_t rows[$];
    thresh_q = ThreshReset;
    ir_dc  = '0;
    red_dc = '0;
    slot   = 0;
    for (int i = 0; i < Depth; i++) begin
      ir_res[i]  = 0;
      red_res[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed requests at the reset threshold.
    rows = '{
      '{18'd0, 18'd0, 1'b1, 7'd0},
      '{18'd49999, SBits'(MaxSample), 1'b1, 7'd0},
      '{SBits'(MaxSample), 18'd49999, 1'b1, 7'd0},
      '{18'd50000, 18'd50000, 1'b0, 7'd0},
      '{SBits'(MaxSample), SBits'(MaxSample), 1'b0, 7'd0},
      '{18'h20000, 18'h10000, 1'b0, 7'd0},
      '{18'h10000, 18'h20000, 1'b0, 7'd0},
      '{18'd200000, 18'd200000, 1'b0, 7'd0},
      '{18'd100000, 18'd150000, 1'b0, 7'd0},
      '{18'h15555, 18'h2AAAA, 1'b0, 7'd0},
      '{18'h2AAAA, 18'h15555, 1'b0, 7'd0},
      '{18'd0, 18'd100000, 1'b1, 7'd0}
    };
    foreach (rows[i]) send_sample(rows[i].red, rows[i].ir, rows[i].known, rows[i].pct);
    send_burst(150);
    drain();

    // Zero threshold: every sample passes.
    write_threshold('0);
    send_burst(120);
    drain();

    // Maximum threshold: only full-scale samples pass.
    write_threshold(ThreshBits'(MaxSample));
    send_sample(SBits'(MaxSample - 1), SBits'(MaxSample), 1'b1, 7'd0);
    send_sample(SBits'(MaxSample), SBits'(MaxSample - 1), 1'b1, 7'd0);
    for (int i = 0; i < 10; i++) send_sample(SBits'(MaxSample), SBits'(MaxSample), 1'b0, '0);
    send_burst(10);
    drain();

    // A random threshold, then back to the reset value.
    write_threshold(ThreshBits'($urandom_range(1, 150000)));
    send_burst(100);
    drain();
    write_threshold(ThreshReset);
    send_burst(60);
    drain();

    $display("Sent %0d requests over five thresholds; checked %0d results", n_sent, n_checked);
    $display("(%0d readings in range, %0d zero).", n_reading, n_zero);
    if (errors == 0 && pending_spo2.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
